@@ sv/bffa_pkg.sv @@
// Shared constants, codes and types for the bitmap first-free allocator.
package bffa_pkg;

  localparam int NUM_ENTRIES = 4096;
  // Word size is a power of two: entry positions split into word and bit fields.
  localparam int WORD_BITS   = 64;
  localparam int NUM_WORDS   = (NUM_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int FIELD_W     = 13;
  localparam int ENC_W       = (NUM_WORDS > WORD_BITS) ? NUM_WORDS : WORD_BITS;
  localparam int ENC_IDX_W   = $clog2(ENC_W);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef logic [ENC_W-1:0]     enc_vec_t;
  typedef logic [ENC_IDX_W-1:0] enc_idx_t;

  typedef struct packed {
    logic     found;
    enc_idx_t idx;
  } ffz_res_t;

endpackage

@@ sv/bffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bffa_ffz.sv @@
// Find-first-zero priority encoder, shared by the word search and the bit search.
module bffa_ffz (
  input  bffa_pkg::enc_vec_t vec,
  output bffa_pkg::ffz_res_t res
);

  always_comb begin
    res.found = 1'b0;
    res.idx   = '0;
    // Scan from the top so the lowest clear bit wins.
    for (int i = bffa_pkg::ENC_W - 1; i >= 0; i--) begin
      if (!vec[i]) begin
        res.found = 1'b1;
        res.idx   = bffa_pkg::ENC_IDX_W'(i);
      end
    end
  end

endmodule

@@ sv/bitmap_first_free_allocator_top.sv @@
// Top level of the bitmap first-free allocator: sequencer, full flags and bitmap RAM.
//
//  channel  | ports                                             | handshake
//  ---------+---------------------------------------------------+---------------------------
//  command  | in_cmd, in_entry_number                           | start high, busy low
//  result   | out_allocated_number, out_status, out_used_count  | out_valid, one cycle
//
// In an allocate, the accept cycle runs the shared encoder over the full flags and
// addresses the bitmap RAM, the next cycle runs the same encoder over the read word
// and writes the word back. A valid free addresses the word of its number on accept
// and clears the bit in S_FIND, if it was set. A full map or a bad number is answered
// from the accept cycle. The result shows on out_valid in the cycle after the last
// work cycle. Reset clears the sequencer, the full flags, the count and a per-word
// valid bit; a word never written reads as all free. The receiver cannot stall.
module bitmap_first_free_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_cmd,
  input  logic [bffa_pkg::FIELD_W-1:0]   in_entry_number,
  output logic                           out_valid,
  output logic [bffa_pkg::FIELD_W-1:0]   out_allocated_number,
  output logic [1:0]                     out_status,
  output logic [bffa_pkg::FIELD_W-1:0]   out_used_count
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FIND = 1'b1;

  logic state_r, state_nxt;
  logic cmd_r, cmd_nxt;
  logic [bffa_pkg::WORD_IDX_W-1:0] widx_r, widx_nxt;
  logic [bffa_pkg::BIT_IDX_W-1:0]  bidx_r, bidx_nxt;
  logic [bffa_pkg::FIELD_W-1:0]    used_r, used_nxt;
  logic [bffa_pkg::NUM_WORDS-1:0]  flags_r, flags_nxt;
  logic [bffa_pkg::NUM_WORDS-1:0]  valid_r, valid_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [bffa_pkg::FIELD_W-1:0]    out_num_r, out_num_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;

  bffa_pkg::enc_vec_t enc_in;
  bffa_pkg::ffz_res_t enc_res;

  logic                            ram_we;
  logic [bffa_pkg::WORD_IDX_W-1:0] ram_raddr;
  logic [bffa_pkg::WORD_BITS-1:0]  ram_rdata;
  logic [bffa_pkg::WORD_BITS-1:0]  ram_wdata;
  logic [bffa_pkg::WORD_BITS-1:0]  word;
  logic [bffa_pkg::WORD_BITS-1:0]  bit_mask;
  logic [bffa_pkg::BIT_IDX_W-1:0]  alloc_bit;
  logic [31:0]                     free_pos;
  logic [31:0]                     alloc_pos;
  logic                            accept;
  logic                            num_bad;

  bffa_ram #(
    .WIDTH(bffa_pkg::WORD_BITS),
    .DEPTH(bffa_pkg::NUM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(widx_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bffa_ffz u_ffz (
    .vec(enc_in),
    .res(enc_res)
  );

  assign accept   = start && (state_r == S_IDLE);
  assign num_bad  = (in_entry_number == '0) ||
                    (32'(in_entry_number) > 32'(bffa_pkg::NUM_ENTRIES));
  assign free_pos = 32'(in_entry_number) - 32'd1;
  assign word     = valid_r[widx_r] ? ram_rdata : '0;
  assign alloc_bit = enc_res.idx[bffa_pkg::BIT_IDX_W-1:0];
  assign alloc_pos = (32'(widx_r) << bffa_pkg::BIT_IDX_W) | 32'(alloc_bit);

  always_comb begin
    // Words past the map and bits past the word read as taken.
    enc_in = '1;
    if (state_r == S_IDLE) begin
      enc_in[bffa_pkg::NUM_WORDS-1:0] = flags_r;
    end else begin
      enc_in[bffa_pkg::WORD_BITS-1:0] = word;
    end
  end

  always_comb begin
    ram_raddr = enc_res.idx[bffa_pkg::WORD_IDX_W-1:0];
    if (in_cmd == bffa_pkg::CMD_FREE) begin
      ram_raddr = free_pos[bffa_pkg::BIT_IDX_W +: bffa_pkg::WORD_IDX_W];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    widx_nxt       = widx_r;
    bidx_nxt       = bidx_r;
    used_nxt       = used_r;
    flags_nxt      = flags_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = 1'b0;
    out_num_nxt    = out_num_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_wdata      = word;
    bit_mask       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          if (in_cmd == bffa_pkg::CMD_ALLOC) begin
            if (enc_res.found) begin
              widx_nxt  = enc_res.idx[bffa_pkg::WORD_IDX_W-1:0];
              state_nxt = S_FIND;
            end else begin
              out_valid_nxt  = 1'b1;
              out_num_nxt    = '0;
              out_status_nxt = bffa_pkg::ST_FULL;
            end
          end else if (num_bad) begin
            out_valid_nxt  = 1'b1;
            out_num_nxt    = '0;
            out_status_nxt = bffa_pkg::ST_BAD;
          end else begin
            widx_nxt  = free_pos[bffa_pkg::BIT_IDX_W +: bffa_pkg::WORD_IDX_W];
            bidx_nxt  = free_pos[bffa_pkg::BIT_IDX_W-1:0];
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_num_nxt    = '0;
        out_status_nxt = bffa_pkg::ST_OK;
        if (cmd_r == bffa_pkg::CMD_ALLOC) begin
          if (!enc_res.found || (alloc_pos >= 32'(bffa_pkg::NUM_ENTRIES))) begin
            out_status_nxt = bffa_pkg::ST_FULL;
          end else begin
            bit_mask          = bffa_pkg::WORD_BITS'(1) << alloc_bit;
            ram_wdata         = word | bit_mask;
            ram_we            = 1'b1;
            valid_nxt[widx_r] = 1'b1;
            flags_nxt[widx_r] = &ram_wdata;
            used_nxt          = used_r + 1'b1;
            out_num_nxt       = bffa_pkg::FIELD_W'(alloc_pos + 32'd1);
          end
        end else begin
          // Lower the count only when the bit was really set.
          if (word[bidx_r]) begin
            bit_mask          = bffa_pkg::WORD_BITS'(1) << bidx_r;
            ram_wdata         = word & ~bit_mask;
            ram_we            = 1'b1;
            valid_nxt[widx_r] = 1'b1;
            flags_nxt[widx_r] = 1'b0;
            used_nxt          = used_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      flags_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      flags_r     <= flags_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    widx_r       <= widx_nxt;
    bidx_r       <= bidx_nxt;
    out_num_r    <= out_num_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_allocated_number = out_num_r;
  assign out_status           = out_status_r;
  assign out_used_count       = used_r;

endmodule

@@ sim/testbench.sv @@
// Testbench for the bitmap first-free allocator: queued command driver, predictor and result checker.
module testbench;

  typedef struct packed {
    logic                         cmd;
    logic [bffa_pkg::FIELD_W-1:0] num;
  } req_t;

  typedef struct packed {
    logic [bffa_pkg::FIELD_W-1:0] num;
    logic [1:0]                   status;
    logic [bffa_pkg::FIELD_W-1:0] used;
  } resp_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         in_cmd = bffa_pkg::CMD_ALLOC;
  logic [bffa_pkg::FIELD_W-1:0] in_entry_number = '0;
  logic                         busy;
  logic                         out_valid;
  logic [bffa_pkg::FIELD_W-1:0] out_allocated_number;
  logic [1:0]                   out_status;
  logic [bffa_pkg::FIELD_W-1:0] out_used_count;

  // Predicted allocator state
  logic [bffa_pkg::WORD_BITS-1:0] map_words [bffa_pkg::NUM_WORDS];
  logic [bffa_pkg::NUM_WORDS-1:0] full_flags;
  logic [bffa_pkg::FIELD_W-1:0]   used_total;

  req_t  req_q[$];
  resp_t resp_q[$];
  req_t  cur_req;
  resp_t next_resp;
  resp_t want_resp;
  logic  no_idle = 1'b0;

  int errors = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_alloc_ok = 0;
  int n_full = 0;
  int n_bad = 0;
  int n_freed = 0;

  bitmap_first_free_allocator_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_entry_number      (in_entry_number),
    .out_valid            (out_valid),
    .out_allocated_number (out_allocated_number),
    .out_status           (out_status),
    .out_used_count       (out_used_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic resp_t apply_request(req_t rq);
    resp_t rs;
    int    w;
    int    b;
    int    pos;
    logic  found;
    logic  stop;
    rs.num = '0;
    rs.status = bffa_pkg::ST_OK;
    if (rq.cmd == bffa_pkg::CMD_ALLOC) begin
      found = 1'b0;
      stop = 1'b0;
      for (w = 0; w < bffa_pkg::NUM_WORDS && !found && !stop; w++) begin
        if (!full_flags[w]) begin
          b = 0;
          while (b < bffa_pkg::WORD_BITS && map_words[w][b]) b++;
          if (b < bffa_pkg::WORD_BITS) begin
            pos = w * bffa_pkg::WORD_BITS + b;
            // lowest clear bit past the last entry: map counts as full
            if (pos >= bffa_pkg::NUM_ENTRIES) begin
              stop = 1'b1;
            end else begin
              map_words[w][b] = 1'b1;
              full_flags[w] = &map_words[w];
              used_total = used_total + 1'b1;
              rs.num = bffa_pkg::FIELD_W'(pos + 1);
              found = 1'b1;
            end
          end
        end
      end
      if (!found) rs.status = bffa_pkg::ST_FULL;
    end else if (rq.num == 0 || rq.num > bffa_pkg::NUM_ENTRIES) begin
      rs.status = bffa_pkg::ST_BAD;
    end else begin
      pos = int'(rq.num) - 1;
      w = pos / bffa_pkg::WORD_BITS;
      b = pos % bffa_pkg::WORD_BITS;
      // count drops only when the bit was really set
      if (map_words[w][b]) begin
        map_words[w][b] = 1'b0;
        full_flags[w] = &map_words[w];
        used_total = used_total - 1'b1;
      end
    end
    rs.used = used_total;
    return rs;
  endfunction

  // Some entry that is currently held, or any valid number when none is
  function automatic logic [bffa_pkg::FIELD_W-1:0] pick_set_entry();
    int                           origin;
    int                           i;
    int                           p;
    logic [bffa_pkg::FIELD_W-1:0] hit;
    origin = $urandom_range(bffa_pkg::NUM_ENTRIES - 1);
    hit = bffa_pkg::FIELD_W'(origin + 1);
    for (i = 0; i < bffa_pkg::NUM_ENTRIES; i++) begin
      p = (origin + i) % bffa_pkg::NUM_ENTRIES;
      if (map_words[p / bffa_pkg::WORD_BITS][p % bffa_pkg::WORD_BITS]) begin
        hit = bffa_pkg::FIELD_W'(p + 1);
        i = bffa_pkg::NUM_ENTRIES;
      end
    end
    return hit;
  endfunction

  task automatic push_req(logic c, int n);
    req_t r;
    r.cmd = c;
    r.num = bffa_pkg::FIELD_W'(n);
    req_q.push_back(r);
  endtask

  task automatic wait_accepted();
    while (req_q.size() != 0 || start) @(negedge clk);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= 30)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               field, n_results, got, want);
  endtask

  // Driver: predict on accept, then present the next request or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        next_resp = apply_request(cur_req);
        resp_q.push_back(next_resp);
        n_accepted++;
        case (next_resp.status)
          bffa_pkg::ST_FULL: n_full++;
          bffa_pkg::ST_BAD:  n_bad++;
          default: if (cur_req.cmd == bffa_pkg::CMD_ALLOC) n_alloc_ok++; else n_freed++;
        endcase
      end
      if (!start || !busy) begin
        if (req_q.size() > 0 && (no_idle || $urandom_range(99) >= 12)) begin
          cur_req = req_q.pop_front();
          start <= 1'b1;
          in_cmd <= cur_req.cmd;
          in_entry_number <= cur_req.num;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: sample mid-cycle, away from the edge that updates expectations
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (resp_q.size() == 0) begin
        report_mismatch("unexpected word", int'(out_allocated_number), -1);
      end else begin
        want_resp = resp_q.pop_front();
        if (out_allocated_number !== want_resp.num)
          report_mismatch("allocated_number", int'(out_allocated_number), int'(want_resp.num));
        if (out_status !== want_resp.status)
          report_mismatch("status", int'(out_status), int'(want_resp.status));
        if (out_used_count !== want_resp.used)
          report_mismatch("used_count", int'(out_used_count), int'(want_resp.used));
      end
      n_results++;
    end
  end

  initial begin : stimulus
    int i;
    int n_random;
    int mode;
    int alloc_pct;
    int r;
    for (i = 0; i < bffa_pkg::NUM_WORDS; i++) map_words[i] = '0;
    full_flags = '0;
    used_total = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: bad numbers, clear frees, lowest-first reuse
    push_req(bffa_pkg::CMD_FREE, 0);
    push_req(bffa_pkg::CMD_FREE, bffa_pkg::NUM_ENTRIES);
    push_req(bffa_pkg::CMD_FREE, bffa_pkg::NUM_ENTRIES + 1);
    push_req(bffa_pkg::CMD_FREE, 8191);
    push_req(bffa_pkg::CMD_ALLOC, 0);
    push_req(bffa_pkg::CMD_ALLOC, 8191);
    push_req(bffa_pkg::CMD_ALLOC, 4096);
    push_req(bffa_pkg::CMD_FREE, 1);
    push_req(bffa_pkg::CMD_FREE, 1);
    push_req(bffa_pkg::CMD_ALLOC, 0);
    push_req(bffa_pkg::CMD_FREE, 2);
    push_req(bffa_pkg::CMD_FREE, 3);
    push_req(bffa_pkg::CMD_ALLOC, 5461);
    push_req(bffa_pkg::CMD_FREE, 2730);
    wait_accepted();

    // climb through the first few words back to back, with no idling
    for (i = 0; i < 200; i++) push_req(bffa_pkg::CMD_ALLOC, $urandom_range(8191));
    no_idle = 1'b1;
    wait_accepted();
    no_idle = 1'b0;

    // holes at the top and at a word boundary
    push_req(bffa_pkg::CMD_FREE, bffa_pkg::NUM_ENTRIES);
    push_req(bffa_pkg::CMD_ALLOC, 0);
    push_req(bffa_pkg::CMD_ALLOC, 0);
    push_req(bffa_pkg::CMD_FREE, bffa_pkg::WORD_BITS + 1);
    push_req(bffa_pkg::CMD_FREE, bffa_pkg::WORD_BITS);
    push_req(bffa_pkg::CMD_FREE, bffa_pkg::NUM_ENTRIES + 1);
    push_req(bffa_pkg::CMD_ALLOC, 0);
    push_req(bffa_pkg::CMD_ALLOC, 0);
    push_req(bffa_pkg::CMD_ALLOC, 0);
    wait_accepted();

    n_random = 0;
    while (n_random < 325) begin
      mode = $urandom_range(2);
      alloc_pct = (mode == 0) ? 65 : (mode == 1) ? 45 : 20;
      repeat (25) begin
        r = $urandom_range(99);
        if (r < 10)
          push_req(bffa_pkg::CMD_FREE, $urandom_range(8191));
        else if (r < 10 + alloc_pct)
          push_req(bffa_pkg::CMD_ALLOC, $urandom_range(8191));
        else
          push_req(bffa_pkg::CMD_FREE, pick_set_entry());
        n_random++;
      end
      wait_accepted();
    end

    while (resp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d requests accepted, %0d results checked", n_accepted, n_results);
    $display("%0d allocations, %0d frees, %0d full-map answers, %0d bad numbers",
             n_alloc_ok, n_freed, n_full, n_bad);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", resp_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
